>>> design/rbd_pkg.sv
// rbd_pkg: shared types, constants and helpers for the rgba 2x2 box downsampler
// used by rbd_lane, rbd_line_store and rgba_box_downsample_2x2; no dependencies
package rbd_pkg;

	// default maximum source width and fixed height limit
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int HEIGHT_LIMIT  = 2048;

	// size register width and reset value
	localparam int CFG_W     = 12;
	localparam int CFG_RESET = 2048;

	// one source pixel word
	typedef struct packed {
		logic [7:0] chan3_in;
		logic [7:0] chan2_in;
		logic [7:0] chan1_in;
		logic [7:0] chan0_in;
	} pix_in_t;

	// one downsampled pixel word
	typedef struct packed {
		logic [7:0] chan0_out;
		logic [7:0] chan1_out;
		logic [7:0] chan2_out;
		logic [7:0] chan3_out;
		logic       frame_last;
	} pix_out_t;

	// horizontal pair sum of one channel, and of all four channels
	typedef logic [8:0] psum_t;
	typedef psum_t [3:0] quad_sum_t;

	// largest power of two not above v, minus one; never below one
	function automatic logic [12:0] pow2_mask(input logic [12:0] v);
		logic [12:0] s;
		s = v;
		s = s | (s >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		return (s >> 1) | 13'd1;
	endfunction

endpackage

>>> design/rbd_lane.sv
// rbd_lane: one byte channel of the 2x2 box filter (pair sum and block average)
// depends on rbd_pkg
module rbd_lane (
	input  logic [7:0]     first,
	input  logic [7:0]     pix,
	input  rbd_pkg::psum_t above,
	input  rbd_pkg::psum_t pair_in,
	output rbd_pkg::psum_t pair_sum,
	output logic [7:0]     avg
);
	import rbd_pkg::*;

	logic [9:0] block_sum;

	// horizontal sum of the even and odd column pixel
	assign pair_sum = {1'b0, first} + {1'b0, pix};

	// add the row above and divide by four, truncating
	assign block_sum = {1'b0, pair_in} + {1'b0, above};
	assign avg       = block_sum[9:2];

endmodule

>>> design/rbd_line_store.sv
// rbd_line_store: line memory of horizontal pair sums, one write and one read port
// depends on rbd_pkg
module rbd_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  rbd_pkg::quad_sum_t   wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output rbd_pkg::quad_sum_t   rd_data
);
	import rbd_pkg::*;

	quad_sum_t mem [DEPTH];
	quad_sum_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/rgba_box_downsample_2x2.sv
// rgba_box_downsample_2x2: 2x2 box-filter mipmap step for rgba8 pixel streams
// depends on rbd_pkg, rbd_lane and rbd_line_store
//
// Source pixels enter on in_data in raster order, one word per cycle when
// in_valid is high and in_stall is low. On even rows the horizontal pair sums
// go to a line memory; on odd rows every completed pair is added to the sum
// above it and one averaged pixel leaves on out_data, with frame_last set on
// the last pixel of the frame. The frame size comes from src_width (address 0)
// and src_height (address 4) on the apb port; a write restarts the frame.
// Sizes are rounded down to a power of two within 2..MAX_WIDTH and 2..2048.
// Throughput is one source pixel per cycle while in_stall is low, set by four
// channel lanes working side by side and one line memory write or read per
// pixel pair. The result of the odd-row, odd-column pixel passes the line
// memory read and pair sum register, then the output register, to out_valid.
// Reset clears the counters and pipeline valids; sizes return to 2048. While
// out_stall holds a result, the stage before it still accepts one more result
// word and even-row pixels flow until that stage is full, then in_stall rises.
module rgba_box_downsample_2x2 #(
	parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// pixel input
	input  logic              in_valid,
	output logic              in_stall,
	input  rbd_pkg::pix_in_t  in_data,
	// pixel output
	output logic              out_valid,
	input  logic              out_stall,
	output rbd_pkg::pix_out_t out_data,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import rbd_pkg::*;

	localparam int SD = MAX_WIDTH / 2;
	localparam int AW = $clog2(SD);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(HEIGHT_LIMIT);

	localparam logic [12:0] W_LIM = (MAX_WIDTH > 4095) ? 13'd4095 : 13'(MAX_WIDTH);
	localparam logic [12:0] H_LIM = 13'(HEIGHT_LIMIT);
	localparam logic [12:0] W_RST = (13'(CFG_RESET) > W_LIM) ? W_LIM : 13'(CFG_RESET);
	localparam logic [12:0] H_RST = (13'(CFG_RESET) > H_LIM) ? H_LIM : 13'(CFG_RESET);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// configuration registers and derived size masks
	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    wmask_q;
	logic [RW-1:0]    hmask_q;
	logic [12:0]      wr_val, w_clamp, h_clamp;
	logic             cfg_wr;

	// frame position
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [3:0][7:0]  first_q;
	logic [3:0][7:0]  pix;

	// pipeline control
	logic             acc, emit, store_wr, frame_end;
	logic             v_s1, last_s1;
	logic             out_free, s1_free, s1_adv;
	quad_sum_t        pair_now, pair_s1, above;
	logic [3:0][7:0]  avg;
	pix_out_t         out_q;
	logic             out_valid_q;

	// apb decode, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, height_q} : {20'd0, width_q};

	// clamp written value to the size limits
	assign wr_val  = {1'b0, pwdata[CFG_W-1:0]};
	assign w_clamp = (wr_val > W_LIM) ? W_LIM : wr_val;
	assign h_clamp = (wr_val > H_LIM) ? H_LIM : wr_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(CFG_RESET);
			height_q <= CFG_W'(CFG_RESET);
			wmask_q  <= CW'(pow2_mask(W_RST));
			hmask_q  <= RW'(pow2_mask(H_RST));
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[CFG_W-1:0];
				wmask_q <= CW'(pow2_mask(w_clamp));
			end else begin
				height_q <= pwdata[CFG_W-1:0];
				hmask_q  <= RW'(pow2_mask(h_clamp));
			end
		end
	end

	// handshake and stage advance
	assign out_free  = ~out_valid_q | ~out_stall;
	assign s1_adv    = v_s1 & out_free;
	assign s1_free   = ~v_s1 | out_free;
	assign in_stall  = ~s1_free;
	assign acc       = in_valid & s1_free;
	assign emit      = acc & col_q[0] & row_q[0];
	assign store_wr  = acc & col_q[0] & ~row_q[0];
	assign frame_end = (col_q == wmask_q) && (row_q == hmask_q);

	assign pix = {in_data.chan3_in, in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == wmask_q) begin
				col_q <= '0;
				row_q <= (row_q == hmask_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// even column pixel waits for its partner
	always_ff @(posedge clk) begin
		if (acc && !col_q[0]) begin
			first_q <= pix;
		end
	end

	// four channel lanes
	for (genvar k = 0; k < 4; k++) begin : g_lane
		rbd_lane u_lane (
			.first    (first_q[k]),
			.pix      (pix[k]),
			.above    (above[k]),
			.pair_in  (pair_s1[k]),
			.pair_sum (pair_now[k]),
			.avg      (avg[k])
		);
	end

	// line memory: written on even rows, read on odd rows
	rbd_line_store #(
		.DEPTH (SD),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (col_q[AW:1]),
		.wr_data (pair_now),
		.rd_en   (emit),
		.rd_addr (col_q[AW:1]),
		.rd_data (above)
	);

	// stage 1 and output register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pair_s1 <= pair_now;
			last_s1 <= frame_end;
		end
	end

	// merge lanes into the output word
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.chan0_out  <= avg[0];
			out_q.chan1_out  <= avg[1];
			out_q.chan2_out  <= avg[2];
			out_q.chan3_out  <= avg[3];
			out_q.frame_last <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
